[sv/sam_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sam_pkg
// Types and constants shared by the shift-and pattern matcher.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int SAM_PATTERN_MAX_DEF   = 64;
    localparam int SAM_ALPHABET_SIZE_DEF = 256;

    localparam int SAM_OP_W     = 2;
    localparam int SAM_INDEX_W  = 6;
    localparam int SAM_BYTE_W   = 8;
    localparam int SAM_LENGTH_W = 7;
    localparam int SAM_POS_W    = 32;

    typedef enum logic [SAM_OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

endpackage : sam_pkg
`default_nettype wire

[sv/sam_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sam_in_if
// Input channel: op, pattern index and byte, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sam_in_if
    import sam_pkg::*;
();
    logic                   valid;
    logic                   ready;
    t_op                    op;
    logic [SAM_INDEX_W-1:0] pattern_index;
    logic [SAM_BYTE_W-1:0]  byte_value;

    modport source (output valid, output op, output pattern_index, output byte_value,
                    input ready);
    modport sink   (input valid, input op, input pattern_index, input byte_value,
                    output ready);
endinterface : sam_in_if
`default_nettype wire

[sv/sam_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sam_out_if
// Result channel: match flag and match start, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sam_out_if
    import sam_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 match_found;
    logic [SAM_POS_W-1:0] match_start;

    modport source (output valid, output match_found, output match_start, input ready);
    modport sink   (input valid, input match_found, input match_start, output ready);
endinterface : sam_out_if
`default_nettype wire

[sv/shift_and_pattern_matcher_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shift_and_pattern_matcher_top
// Shift-and exact matcher for one pattern of up to PATTERN_MAX bytes.
// ----------------------------------------------------------------------------
// i_in carries one op per beat: clear table, load a pattern byte, feed a
// text byte, or restart the text. o_out returns exactly one beat per input
// beat, in order; match_found/match_start are nonzero only for a text byte
// that ends a pattern occurrence.
// i_cfg_we/i_cfg_wdata write pattern_length; write it only while idle.
// The mask table read (registered) happens at the accept edge; the vector
// update and result register load happen at the edge where the beat
// advances out of the middle stage. One beat per cycle is sustained while
// o_out does not stall; the table takes one access per cycle on a single port.
// Reset and the clear op mark all table entries invalid at once (one valid
// flop per entry), so no clearing pass is needed. Reset also sets the
// vector and position to zero and pattern_length to 1.
// When o_out stalls, the result stays in the output register, one more beat
// waits in the middle stage, and i_in.ready drops until o_out moves again.
// ----------------------------------------------------------------------------
module shift_and_pattern_matcher_top
    import sam_pkg::*;
#(
    parameter int PATTERN_MAX   = SAM_PATTERN_MAX_DEF,
    parameter int ALPHABET_SIZE = SAM_ALPHABET_SIZE_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [SAM_LENGTH_W-1:0] i_cfg_wdata,
    sam_in_if.sink                       i_in,
    sam_out_if.source                    o_out
);

    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    // config
    logic [SAM_LENGTH_W-1:0] r_pattern_length;

    // mask table
    logic [PATTERN_MAX-1:0]   r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_entry_valid;
    logic [PATTERN_MAX-1:0]   r_rd_data;
    logic                     r_rd_valid;

    // middle stage
    logic r_s1_valid;
    t_op  r_s1_op;

    // search state
    logic [PATTERN_MAX-1:0] r_active;
    logic [PATTERN_MAX-1:0] n_active;
    logic [SAM_POS_W-1:0]   r_position;
    logic [SAM_POS_W-1:0]   n_position;

    // output register
    logic                 r_out_valid;
    logic                 r_match_found;
    logic [SAM_POS_W-1:0] r_match_start;
    logic                 n_match_found;
    logic [SAM_POS_W-1:0] n_match_start;

    logic                    accept;
    logic                    advance;
    logic [AW-1:0]           addr;
    logic                    byte_ok;
    logic                    index_ok;
    logic                    do_load;
    logic [PATTERN_MAX-1:0]  load_onehot;
    logic [PATTERN_MAX-1:0]  mask;
    logic [SAM_LENGTH_W-1:0] len_eff;
    logic                    hit;

    assign advance    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    assign addr     = AW'(i_in.byte_value);
    assign byte_ok  = {1'b0, i_in.byte_value} < (SAM_BYTE_W+1)'(ALPHABET_SIZE);
    assign index_ok = {1'b0, i_in.pattern_index} < SAM_LENGTH_W'(PATTERN_MAX);
    assign do_load  = accept && (i_in.op == OP_LOAD) && byte_ok && index_ok;

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            load_onehot[j] = (i_in.pattern_index == SAM_INDEX_W'(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= SAM_LENGTH_W'(1);
        end else if (i_cfg_we) begin
            r_pattern_length <= i_cfg_wdata;
        end
    end

    // Table array: bit-enabled write, registered read, same edge as accept
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            if (!r_entry_valid[addr]) begin
                r_mem[addr] <= load_onehot;
            end else begin
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    if (load_onehot[j]) begin
                        r_mem[addr][j] <= 1'b1;
                    end
                end
            end
        end
        if (accept) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (accept && (i_in.op == OP_CLEAR)) begin
            r_entry_valid <= '0;
        end else if (do_load) begin
            r_entry_valid[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_valid <= byte_ok && r_entry_valid[addr];
            r_s1_op    <= i_in.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign mask    = r_rd_valid ? r_rd_data : '0;
    assign len_eff = (r_pattern_length > SAM_LENGTH_W'(PATTERN_MAX))
                     ? SAM_LENGTH_W'(PATTERN_MAX) : r_pattern_length;

    always_comb begin
        n_active      = r_active;
        n_position    = r_position;
        n_match_found = 1'b0;
        n_match_start = '0;
        hit           = 1'b0;
        case (r_s1_op)
            OP_CLEAR, OP_RESTART: begin
                n_active   = '0;
                n_position = '0;
            end
            OP_TEXT: begin
                n_active = ((r_active << 1) | PATTERN_MAX'(1)) & mask;
                // tested bit is len_eff-1; a zero length tests nothing
                for (int j = 0; j < PATTERN_MAX; j++) begin
                    if (len_eff == SAM_LENGTH_W'(j + 1)) begin
                        hit = n_active[j];
                    end
                end
                n_match_found = hit;
                n_match_start = hit
                    ? (r_position - SAM_POS_W'(len_eff) + SAM_POS_W'(1)) : '0;
                n_position = r_position + SAM_POS_W'(1);
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_position <= '0;
        end else if (advance) begin
            r_active   <= n_active;
            r_position <= n_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_match_found <= n_match_found;
            r_match_start <= n_match_start;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.match_found = r_match_found;
    assign o_out.match_start = r_match_start;

endmodule : shift_and_pattern_matcher_top
`default_nettype wire
